/* hw/rtl/assert_macros.svh */
// Assertion macros used by the port-level checker of this block.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, masked while reset is asserted
`define SWS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that is also checked during reset
`define SWS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/sws_pkg.sv */
// Shared types and constants of the sliding-window slope estimator.
// No dependencies; used by the controller, the datapath and the top level.
package sws_pkg;

  localparam int unsigned SLOPE_W = 48;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned WIN_W = 5;

  localparam logic [WIN_W-1:0] WIN_RESET = 5'd16;

  localparam logic [STATUS_W-1:0] STATUS_VALID = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_SHORT = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FLAT  = 2'd2;

  localparam logic [SLOPE_W-1:0] SLOPE_MAX = {1'b0, {(SLOPE_W-1){1'b1}}};
  localparam logic [SLOPE_W-1:0] SLOPE_MIN = {1'b1, {(SLOPE_W-1){1'b0}}};

  // Which result the output register is loaded with
  typedef enum logic [1:0] {
    KIND_FIT    = 2'd0,
    KIND_SHORT  = 2'd1,
    KIND_FLAT   = 2'd2,
    KIND_REPEAT = 2'd3
  } out_kind_e;

  // Controller to datapath commands
  typedef struct packed {
    logic      in_take;
    logic      store;
    logic      scan_init;
    logic      scan_issue;
    logic      load_a;
    logic      load_b;
    logic      mul_step;
    logic      mul_sub;
    logic      div_load;
    logic      div_step;
    logic      out_load;
    out_kind_e out_kind;
  } sws_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_repeat;
    logic n_small;
    logic scan_done;
    logic pipe_busy;
    logic den_bad;
  } sws_sts_t;

endpackage

/* hw/rtl/sws_ctrl.sv */
// Sequencing state machine of the slope estimator: handshakes and step counts.
// Depends on sws_pkg.
module sws_ctrl #(
  parameter int unsigned MAX_WINDOW    = 16,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_valid_i,
  output logic             s_ready_o,
  output logic             m_valid_o,
  input  logic             m_ready_i,
  output sws_pkg::sws_cmd_t cmd_o,
  input  sws_pkg::sws_sts_t sts_i
);

  localparam int unsigned CW    = $clog2(MAX_WINDOW + 1);
  localparam int unsigned SX_W  = 32 + CW;
  localparam int unsigned ACC_W = 66 + 2 * CW;
  localparam int unsigned DV_W  = ACC_W + FRACTION_BITS;
  localparam int unsigned CNT_W = $clog2(DV_W);

  typedef enum logic [9:0] {
    ST_IDLE     = 10'b0000000001,
    ST_DECIDE   = 10'b0000000010,
    ST_SETUP    = 10'b0000000100,
    ST_SCAN     = 10'b0000001000,
    ST_MUL_A    = 10'b0000010000,
    ST_LOAD_B   = 10'b0000100000,
    ST_MUL_B    = 10'b0001000000,
    ST_DIV_LOAD = 10'b0010000000,
    ST_DIV      = 10'b0100000000,
    ST_EMIT     = 10'b1000000000
  } state_e;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  sws_pkg::out_kind_e kind_q, kind_d;
  logic               out_valid_q, out_valid_d;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    kind_d  = kind_q;
    cmd_o   = '0;
    cmd_o.out_kind = kind_q;
    s_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.in_take = 1'b1;
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (sts_i.is_repeat) begin
          kind_d  = sws_pkg::KIND_REPEAT;
          state_d = ST_EMIT;
        end else begin
          cmd_o.store = 1'b1;
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: begin
        if (sts_i.n_small) begin
          kind_d  = sws_pkg::KIND_SHORT;
          state_d = ST_EMIT;
        end else begin
          cmd_o.scan_init = 1'b1;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_issue = !sts_i.scan_done;
        if (sts_i.scan_done && !sts_i.pipe_busy) begin
          cmd_o.load_a = 1'b1;
          cnt_d   = '0;
          state_d = ST_MUL_A;
        end
      end
      ST_MUL_A: begin
        cmd_o.mul_step = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(CW - 1)) begin
          state_d = ST_LOAD_B;
        end
      end
      ST_LOAD_B: begin
        cmd_o.load_b = 1'b1;
        cnt_d   = '0;
        state_d = ST_MUL_B;
      end
      ST_MUL_B: begin
        cmd_o.mul_step = 1'b1;
        cmd_o.mul_sub  = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(SX_W - 1)) begin
          state_d = ST_DIV_LOAD;
        end
      end
      ST_DIV_LOAD: begin
        if (sts_i.den_bad) begin
          kind_d  = sws_pkg::KIND_FLAT;
          state_d = ST_EMIT;
        end else begin
          cmd_o.div_load = 1'b1;
          cnt_d   = '0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DV_W - 1)) begin
          kind_d  = sws_pkg::KIND_FIT;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || m_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Output register valid flag
  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (m_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign m_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      kind_q      <= sws_pkg::KIND_FIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      kind_q      <= kind_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

/* hw/rtl/sws_datapath.sv */
// Datapath of the slope estimator: history ring, sum pipeline, shift-add
// products, restoring divider and result registers. Depends on sws_pkg.
module sws_datapath #(
  parameter int unsigned MAX_WINDOW    = 16,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sws_pkg::sws_cmd_t             cmd_i,
  output sws_pkg::sws_sts_t             sts_o,
  input  logic [31:0]                   sample_time_i,
  input  logic [31:0]                   sample_value_i,
  input  logic                          cfg_we_i,
  input  logic [sws_pkg::WIN_W-1:0]     cfg_wdata_i,
  output logic [sws_pkg::SLOPE_W-1:0]   slope_o,
  output logic [sws_pkg::STATUS_W-1:0]  status_o,
  output logic                          repeated_o,
  output logic                          saturated_o
);

  localparam int unsigned AW    = $clog2(MAX_WINDOW);
  localparam int unsigned CW    = $clog2(MAX_WINDOW + 1);
  localparam int unsigned WCW   = (CW > sws_pkg::WIN_W) ? CW : sws_pkg::WIN_W;
  localparam int unsigned PW    = CW + 1;
  localparam int unsigned SX_W  = 32 + CW;
  localparam int unsigned SY_W  = 33 + CW;
  localparam int unsigned SXX_W = 64 + CW;
  localparam int unsigned SXY_W = 65 + CW;
  localparam int unsigned ACC_W = 66 + 2 * CW;
  localparam int unsigned DV_W  = ACC_W + FRACTION_BITS;
  localparam int unsigned SW    = sws_pkg::SLOPE_W;

  // Input latch and configuration
  logic [31:0]               t_in_q, v_in_q;
  logic [sws_pkg::WIN_W-1:0] win_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_take) begin
      t_in_q <= sample_time_i;
      v_in_q <= sample_value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= sws_pkg::WIN_RESET;
    end else if (cfg_we_i) begin
      win_q <= cfg_wdata_i;
    end
  end

  // Ring bookkeeping
  logic [AW-1:0] wp_q;
  logic [CW-1:0] held_q;
  logic [31:0]   newest_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      held_q <= '0;
    end else if (cmd_i.store) begin
      wp_q <= (wp_q == AW'(MAX_WINDOW - 1)) ? '0 : wp_q + 1'b1;
      if (held_q != CW'(MAX_WINDOW)) begin
        held_q <= held_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      newest_q <= t_in_q;
    end
  end

  assign sts_o.is_repeat = (held_q != '0) && (newest_q == t_in_q);

  // Points in the fit and oldest entry
  logic [WCW-1:0] win_ext, wl, held_ext, n_ext;
  logic [CW-1:0]  n;
  logic [PW-1:0]  wp_p, n_p, start_p;
  logic [AW-1:0]  start;

  always_comb begin
    win_ext  = WCW'(win_q);
    held_ext = WCW'(held_q);
    if (win_ext < WCW'(2)) begin
      wl = WCW'(2);
    end else if (win_ext > WCW'(MAX_WINDOW)) begin
      wl = WCW'(MAX_WINDOW);
    end else begin
      wl = win_ext;
    end
    n_ext = (held_ext < wl) ? held_ext : wl;
    n     = n_ext[CW-1:0];
    wp_p  = PW'(wp_q);
    n_p   = PW'(n);
    start_p = (wp_p >= n_p) ? wp_p - n_p : wp_p + PW'(MAX_WINDOW) - n_p;
    start = start_p[AW-1:0];
  end

  assign sts_o.n_small = (n < CW'(2));

  // History memory, one write and one registered read per cycle
  logic [31:0]   mem_t [MAX_WINDOW];
  logic [31:0]   mem_v [MAX_WINDOW];
  logic [AW-1:0] rd_ptr_q;
  logic [31:0]   rd_time_q, rd_val_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      mem_t[wp_q] <= t_in_q;
      mem_v[wp_q] <= v_in_q;
    end
    if (cmd_i.scan_issue) begin
      rd_time_q <= mem_t[rd_ptr_q];
      rd_val_q  <= mem_v[rd_ptr_q];
    end
  end

  // Scan address and pipeline valids
  logic [CW-1:0] rd_left_q;
  logic          first_q, rd_first_q, rd_valid_q, d_valid_q, p_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_left_q  <= '0;
      first_q    <= 1'b0;
      rd_valid_q <= 1'b0;
      d_valid_q  <= 1'b0;
      p_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.scan_init) begin
        rd_left_q <= n;
        first_q   <= 1'b1;
      end else if (cmd_i.scan_issue) begin
        rd_left_q <= rd_left_q - 1'b1;
        first_q   <= 1'b0;
      end
      rd_valid_q <= cmd_i.scan_issue;
      d_valid_q  <= rd_valid_q;
      p_valid_q  <= d_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_init) begin
      rd_ptr_q <= start;
    end else if (cmd_i.scan_issue) begin
      rd_ptr_q <= (rd_ptr_q == AW'(MAX_WINDOW - 1)) ? '0 : rd_ptr_q + 1'b1;
      rd_first_q <= first_q;
    end
  end

  assign sts_o.scan_done = (rd_left_q == '0);
  assign sts_o.pipe_busy = rd_valid_q | d_valid_q | p_valid_q;

  // Deltas from the oldest point, then products, then sums
  logic [31:0]              t0_q, v0_q, dt_q, pdt_q;
  logic signed [32:0]       dy_q, pdy_q;
  logic [63:0]              pt_q;
  logic signed [65:0]       py_q;
  logic [SX_W-1:0]          sx_q;
  logic signed [SY_W-1:0]   sy_q;
  logic [SXX_W-1:0]         sxx_q;
  logic signed [SXY_W-1:0]  sxy_q;

  always_ff @(posedge clk_i) begin
    if (rd_valid_q) begin
      if (rd_first_q) begin
        t0_q <= rd_time_q;
        v0_q <= rd_val_q;
        dt_q <= '0;
        dy_q <= '0;
      end else begin
        dt_q <= rd_time_q - t0_q;
        dy_q <= $signed({rd_val_q[31], rd_val_q}) - $signed({v0_q[31], v0_q});
      end
    end
    if (d_valid_q) begin
      pt_q  <= dt_q * dt_q;
      py_q  <= dy_q * $signed({1'b0, dt_q});
      pdt_q <= dt_q;
      pdy_q <= dy_q;
    end
    if (cmd_i.scan_init) begin
      sx_q  <= '0;
      sy_q  <= '0;
      sxx_q <= '0;
      sxy_q <= '0;
    end else if (p_valid_q) begin
      sx_q  <= sx_q + SX_W'(pdt_q);
      sy_q  <= sy_q + SY_W'(pdy_q);
      sxx_q <= sxx_q + SXX_W'(pt_q);
      sxy_q <= sxy_q + SXY_W'(py_q);
    end
  end

  // Shift-add products: n*Sxx, n*Sxy, then minus Sx*Sx, Sx*Sy
  logic signed [ACC_W-1:0] mcand_a_q, mcand_b_q, num_q, den_q;
  logic [SX_W-1:0]         mplier_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_a) begin
      mcand_a_q <= ACC_W'(sxx_q);
      mcand_b_q <= ACC_W'(sxy_q);
      mplier_q  <= SX_W'(n);
      num_q     <= '0;
      den_q     <= '0;
    end else if (cmd_i.load_b) begin
      mcand_a_q <= ACC_W'(sx_q);
      mcand_b_q <= ACC_W'(sy_q);
      mplier_q  <= sx_q;
    end else if (cmd_i.mul_step) begin
      if (mplier_q[0]) begin
        num_q <= cmd_i.mul_sub ? num_q - mcand_b_q : num_q + mcand_b_q;
        den_q <= cmd_i.mul_sub ? den_q - mcand_a_q : den_q + mcand_a_q;
      end
      mcand_a_q <= mcand_a_q <<< 1;
      mcand_b_q <= mcand_b_q <<< 1;
      mplier_q  <= mplier_q >> 1;
    end
  end

  assign sts_o.den_bad = (den_q == '0) || den_q[ACC_W-1];

  // Restoring divider, one quotient bit per cycle
  logic [ACC_W-1:0] mag, rem_q;
  logic [DV_W-1:0]  dq_q;
  logic [ACC_W:0]   trial;
  logic [ACC_W+1:0] diff;
  logic             ge, neg_q;

  always_comb begin
    mag   = num_q[ACC_W-1] ? ACC_W'(-num_q) : ACC_W'(num_q);
    trial = {rem_q, dq_q[DV_W-1]};
    diff  = {1'b0, trial} - {2'b00, den_q};
    ge    = !diff[ACC_W+1];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      dq_q  <= DV_W'(mag) << FRACTION_BITS;
      rem_q <= '0;
      neg_q <= num_q[ACC_W-1];
    end else if (cmd_i.div_step) begin
      rem_q <= ge ? diff[ACC_W-1:0] : trial[ACC_W-1:0];
      dq_q  <= {dq_q[DV_W-2:0], ge};
    end
  end

  // Clip the quotient to the signed output range
  logic          fit_sat;
  logic [SW-1:0] fit_slope;

  always_comb begin
    if (neg_q) begin
      fit_sat = (|dq_q[DV_W-1:SW]) | (dq_q[SW-1] & (|dq_q[SW-2:0]));
    end else begin
      fit_sat = |dq_q[DV_W-1:SW-1];
    end
    if (fit_sat) begin
      fit_slope = neg_q ? sws_pkg::SLOPE_MIN : sws_pkg::SLOPE_MAX;
    end else begin
      fit_slope = neg_q ? SW'(-dq_q[SW-1:0]) : dq_q[SW-1:0];
    end
  end

  // Result registers and the copy kept for repeated times
  logic [SW-1:0]                prev_slope_q;
  logic [sws_pkg::STATUS_W-1:0] prev_status_q;
  logic                         prev_sat_q;
  logic [SW-1:0]                res_slope;
  logic [sws_pkg::STATUS_W-1:0] res_status;
  logic                         res_sat;

  always_comb begin
    case (cmd_i.out_kind)
      sws_pkg::KIND_FIT: begin
        res_slope  = fit_slope;
        res_status = sws_pkg::STATUS_VALID;
        res_sat    = fit_sat;
      end
      sws_pkg::KIND_SHORT: begin
        res_slope  = '0;
        res_status = sws_pkg::STATUS_SHORT;
        res_sat    = 1'b0;
      end
      sws_pkg::KIND_FLAT: begin
        res_slope  = '0;
        res_status = sws_pkg::STATUS_FLAT;
        res_sat    = 1'b0;
      end
      default: begin
        res_slope  = prev_slope_q;
        res_status = prev_status_q;
        res_sat    = prev_sat_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_slope_q  <= '0;
      prev_status_q <= sws_pkg::STATUS_SHORT;
      prev_sat_q    <= 1'b0;
    end else if (cmd_i.out_load && (cmd_i.out_kind != sws_pkg::KIND_REPEAT)) begin
      prev_slope_q  <= res_slope;
      prev_status_q <= res_status;
      prev_sat_q    <= res_sat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      slope_o     <= res_slope;
      status_o    <= res_status;
      saturated_o <= res_sat;
      repeated_o  <= (cmd_i.out_kind == sws_pkg::KIND_REPEAT);
    end
  end

endmodule

/* hw/rtl/sliding_window_slope_estimator.sv */
// Sliding-window least-squares slope estimator, top level.
// Input stream: tdata carries a sample time and value. Output stream: tdata
// carries the slope (signed, FRACTION_BITS fraction bits, truncated toward
// zero); tuser carries status, repeated and saturated flags.
// One item is worked at a time. A sample whose time equals the newest stored
// time is answered from the last result. Otherwise the sample is stored, the
// n points in the fit are scanned into the sums, the shift-add products form
// numerator and denominator, and the restoring divider, one quotient bit per
// cycle, gives the slope (too few points or a non-positive denominator end it
// early). Once the result is loaded the controller returns to idle and
// takes the next input. The result sits in an output register; the next
// sample is accepted while it waits. If the receiver stalls, a finished
// result holds in its state until the register frees up.
// window_length is written through cfg_we_i/cfg_wdata_i; the user must write
// it only while the block is idle; the block itself does not enforce this. Reset
// empties the history, sets window_length to 16, and makes the remembered result "too few points".
// Depends on sws_pkg, sws_ctrl and sws_datapath.
module sliding_window_slope_estimator #(
  parameter int unsigned MAX_WINDOW    = 16,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,   // [31:0] sample_time, [63:32] sample_value
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,   // [47:0] slope
  output logic [3:0]  m_axis_tuser_o,   // [1:0] status, [2] repeated, [3] saturated
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i
);

  sws_pkg::sws_cmd_t cmd;
  sws_pkg::sws_sts_t sts;
  logic [sws_pkg::STATUS_W-1:0] status;
  logic                         repeated, saturated;

  sws_ctrl #(
    .MAX_WINDOW   (MAX_WINDOW),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_valid_i(s_axis_tvalid_i),
    .s_ready_o(s_axis_tready_o),
    .m_valid_o(m_axis_tvalid_o),
    .m_ready_i(m_axis_tready_i),
    .cmd_o    (cmd),
    .sts_i    (sts)
  );

  sws_datapath #(
    .MAX_WINDOW   (MAX_WINDOW),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .sample_time_i (s_axis_tdata_i[31:0]),
    .sample_value_i(s_axis_tdata_i[63:32]),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .slope_o       (m_axis_tdata_o),
    .status_o      (status),
    .repeated_o    (repeated),
    .saturated_o   (saturated)
  );

  assign m_axis_tuser_o = {saturated, repeated, status};

endmodule

/* hw/rtl/sws_checker.sv */
// Port-level checks of the slope estimator, bound to the top level.
// Depends on assert_macros.svh and sws_pkg.
`include "assert_macros.svh"

module sws_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [47:0] m_axis_tdata_o,
  input logic [3:0]  m_axis_tuser_o
);

  // No result is offered while reset is held
  `SWS_ASSERT_ALWAYS(a_no_valid_in_reset, clk_i, !rst_ni |-> !m_axis_tvalid_o, "valid during reset")

  // A stalled result stays offered
  `SWS_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o, "result dropped while stalled")

  // One item at a time: ready drops after a transfer in
  `SWS_ASSERT(a_busy_after_take, clk_i, rst_ni, s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o, "second sample taken while busy")

  // Status code is legal and clipping only happens on a valid fit
  `SWS_ASSERT(a_status_code, clk_i, rst_ni,
    m_axis_tvalid_o |-> (m_axis_tuser_o[1:0] <= sws_pkg::STATUS_FLAT) &&
    (!m_axis_tuser_o[3] || m_axis_tuser_o[1:0] == sws_pkg::STATUS_VALID),
    "bad status or saturation")

  // Failed fits report a zero slope
  `SWS_ASSERT(a_zero_on_fail, clk_i, rst_ni,
    m_axis_tvalid_o && (m_axis_tuser_o[1:0] != sws_pkg::STATUS_VALID) |->
    m_axis_tdata_o == 48'd0, "nonzero slope on failed fit")

endmodule

bind sliding_window_slope_estimator sws_checker u_sws_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .s_axis_tvalid_i(s_axis_tvalid_i),
  .s_axis_tready_o(s_axis_tready_o),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o),
  .m_axis_tuser_o (m_axis_tuser_o)
);

/* tb/sv/sliding_window_slope_estimator_chk.sv */
// Checker for the sliding-window slope estimator: watches both streams and
// the window register port, predicts each result and compares field by field.
// Depends on sws_pkg.
module sliding_window_slope_estimator_chk #(
  parameter int unsigned MAX_WINDOW    = 16,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [63:0] s_axis_tdata_i,
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [47:0] m_axis_tdata_i,
  input  logic [3:0]  m_axis_tuser_i,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [sws_pkg::SLOPE_W-1:0]  slope;
    logic [sws_pkg::STATUS_W-1:0] status;
    logic                         repeated;
    logic                         saturated;
  } fit_result_t;

  // Model copy of the block state
  logic [31:0]               hist_time [MAX_WINDOW];
  logic [31:0]               hist_value [MAX_WINDOW];
  int unsigned               wr_ptr;
  int unsigned               held;
  logic [sws_pkg::WIN_W-1:0] win_reg;
  fit_result_t               last_fit;
  fit_result_t               fits_due [$];

  assign pending_o = fits_due.size();

  // Exact least-squares slope over the newest points, updating history unless the time repeats
  function automatic fit_result_t fit_sample(logic [31:0] t_in, logic [31:0] v_in);
    fit_result_t        r;
    int unsigned        wl, n, first, idx;
    logic [31:0]        t0, dt;
    logic signed [63:0] v0, dy;
    logic signed [159:0] sx, sy, sxx, sxy, num, den, mag, quo, lim;
    r = '0;
    if (held > 0 && hist_time[(wr_ptr + MAX_WINDOW - 1) % MAX_WINDOW] == t_in) begin
      r = last_fit;
      r.repeated = 1'b1;
      return r;
    end
    hist_time[wr_ptr]  = t_in;
    hist_value[wr_ptr] = v_in;
    wr_ptr = (wr_ptr + 1) % MAX_WINDOW;
    if (held < MAX_WINDOW) held++;
    wl = (win_reg < 2) ? 2 : win_reg;
    if (wl > MAX_WINDOW) wl = MAX_WINDOW;
    n = (held < wl) ? held : wl;
    if (n < 2) begin
      r.status = sws_pkg::STATUS_SHORT;
    end else begin
      first = (wr_ptr + MAX_WINDOW - n) % MAX_WINDOW;
      t0 = hist_time[first];
      v0 = $signed(hist_value[first]);
      sx = 0; sy = 0; sxx = 0; sxy = 0;
      for (int k = 0; k < n; k++) begin
        idx = (first + k) % MAX_WINDOW;
        dt  = hist_time[idx] - t0;
        dy  = $signed(hist_value[idx]) - v0;
        sx  += $signed({128'd0, dt});
        sy  += dy;
        sxx += $signed({128'd0, dt}) * $signed({128'd0, dt});
        sxy += $signed({128'd0, dt}) * dy;
      end
      num = sxy * n - sy * sx;
      den = sxx * n - sx * sx;
      if (den <= 0) begin
        r.status = sws_pkg::STATUS_FLAT;
      end else begin
        mag = (num < 0) ? -num : num;
        quo = (mag <<< FRACTION_BITS) / den;
        lim = (num < 0) ? (160'sd1 <<< (sws_pkg::SLOPE_W - 1))
                        : ((160'sd1 <<< (sws_pkg::SLOPE_W - 1)) - 1);
        if (quo > lim) begin
          quo = lim;
          r.saturated = 1'b1;
        end
        r.slope  = (num < 0) ? -quo[sws_pkg::SLOPE_W-1:0] : quo[sws_pkg::SLOPE_W-1:0];
        r.status = sws_pkg::STATUS_VALID;
      end
    end
    last_fit = r;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    fit_result_t got, want;
    if (!rst_ni) begin
      wr_ptr       = 0;
      held         = 0;
      win_reg      = sws_pkg::WIN_RESET;
      last_fit     = '0;
      last_fit.status = sws_pkg::STATUS_SHORT;
      fits_due.delete();
      fail_count_o = 0;
    end else begin
      // Result side first, so the queue holds only earlier samples
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got.slope     = m_axis_tdata_i;
        got.status    = m_axis_tuser_i[1:0];
        got.repeated  = m_axis_tuser_i[2];
        got.saturated = m_axis_tuser_i[3];
        if (fits_due.size() == 0) begin
          $error("unexpected result transfer slope=%h user=%h", m_axis_tdata_i,
                 m_axis_tuser_i);
          fail_count_o++;
        end else begin
          want = fits_due.pop_front();
          if (got.slope !== want.slope) begin
            $error("slope exp %h got %h", want.slope, got.slope); fail_count_o++;
          end
          if (got.status !== want.status) begin
            $error("status exp %0d got %0d", want.status, got.status); fail_count_o++;
          end
          if (got.repeated !== want.repeated) begin
            $error("repeated exp %0d got %0d", want.repeated, got.repeated);
            fail_count_o++;
          end
          if (got.saturated !== want.saturated) begin
            $error("saturated exp %0d got %0d", want.saturated, got.saturated);
            fail_count_o++;
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i)
        fits_due.push_back(fit_sample(s_axis_tdata_i[31:0], s_axis_tdata_i[63:32]));
      if (cfg_we_i) win_reg = cfg_wdata_i;
    end
  end
endmodule

/* tb/sv/sliding_window_slope_estimator_tb.sv */
// Top of the slope estimator testbench: clock, reset, sample stimulus,
// window settings, output stalls and the verdict.
// Depends on sws_pkg, the block and sliding_window_slope_estimator_chk.
module sliding_window_slope_estimator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic [3:0]  m_tuser;
  logic        cfg_we = 1'b0;
  logic [4:0]  cfg_wdata = '0;
  int          fail_count, pending;
  int          quiet_cycles = 0;
  logic [31:0] clock_now = 32'd1000;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  sliding_window_slope_estimator DUT (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i(s_tvalid), .s_axis_tready_o(s_tready), .s_axis_tdata_i(s_tdata),
    .m_axis_tvalid_o(m_tvalid), .m_axis_tready_i(m_tready),
    .m_axis_tdata_o(m_tdata), .m_axis_tuser_o(m_tuser),
    .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata)
  );

  sliding_window_slope_estimator_chk chk (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i(s_tvalid), .s_axis_tready_i(s_tready), .s_axis_tdata_i(s_tdata),
    .m_axis_tvalid_i(m_tvalid), .m_axis_tready_i(m_tready),
    .m_axis_tdata_i(m_tdata), .m_axis_tuser_i(m_tuser),
    .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Receiver stall pattern: ready on just over half of the cycles, stalled on the rest, chosen anew each cycle
  always @(posedge clk_i) begin
    int mode;
    mode = $urandom_range(0, 15);
    if (mode < 9) m_tready <= 1'b1;
    else if (mode < 15) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(0, 3) == 0);
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // One sample transfer; holds valid until accepted
  task automatic send_sample(logic [31:0] t, logic [31:0] v);
    s_tvalid <= 1'b1;
    s_tdata  <= {v, t};
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
  endtask

  task automatic pause_sender(int cycles);
    s_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Drain outstanding results, then let a possible in-flight fit settle
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic set_window(logic [4:0] w);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= w;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  // Random sample: mostly monotonic time, sometimes repeats, jumps or wraps
  task automatic random_sample();
    int sel;
    logic [31:0] v;
    sel = $urandom_range(0, 19);
    case (sel)
      0: ;  // repeat time
      1: clock_now = clock_now + $urandom();
      2: clock_now = 32'hFFFF_FFF0 + $urandom_range(0, 15);
      default: clock_now = clock_now + $urandom_range(1, (sel < 10) ? 8 : 5000);
    endcase
    case ($urandom_range(0, 5))
      0: v = $urandom();
      1: v = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: v = 32'(int'($urandom_range(0, 2000)) - 1000);
    endcase
    send_sample(clock_now, v);
  endtask

  initial begin
    int burst;
    // Reset edge at time zero so the async reset takes effect at once
    rst_ni <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: first sample, repeat before history, extremes, flat time
    send_sample(32'd0, 32'd0);
    send_sample(32'd0, 32'd5);
    send_sample(32'd1, 32'h7FFF_FFFF);
    send_sample(32'd2, 32'h8000_0000);
    send_sample(32'd3, 32'h7FFF_FFFF);
    send_sample(32'd3, 32'd1);
    send_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_sample(32'd0, 32'h7FFF_FFFF);
    send_sample(32'hAAAA_5555, 32'h5555_AAAA);
    send_sample(32'h5555_AAAA, 32'hAAAA_5555);
    // Minimum window, large swings saturate
    set_window(5'd2);
    send_sample(32'd100, 32'h8000_0000);
    send_sample(32'd101, 32'h7FFF_FFFF);
    send_sample(32'd102, 32'h8000_0000);
    send_sample(32'd102, 32'd0);
    // Out-of-range windows
    set_window(5'd0);
    send_sample(32'd200, 32'd10);
    send_sample(32'd201, 32'd20);
    set_window(5'd31);
    send_sample(32'd202, 32'd30);
    set_window(5'd1);
    send_sample(32'd203, 32'd40);
    set_window(5'd16);
    clock_now = 32'd300;

    // Random: window settings change between phases
    for (int phase = 0; phase < 8; phase++) begin
      set_window((phase == 0) ? 5'd2 : (phase == 7) ? 5'd16 : 5'($urandom_range(0, 31)));
      for (int i = 0; i < 160; ) begin
        burst = $urandom_range(1, 12);
        for (int b = 0; b < burst && i < 160; b++, i++) random_sample();
        if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 300));
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/sws_pkg.sv
hw/rtl/sws_ctrl.sv
hw/rtl/sws_datapath.sv
hw/rtl/sliding_window_slope_estimator.sv
hw/rtl/sws_checker.sv
tb/sv/sliding_window_slope_estimator_chk.sv
tb/sv/sliding_window_slope_estimator_tb.sv
